// ===== sv/stepper_phase_sequencer_macros.svh =====
// Assertion shorthands shared by the checker.
`ifndef STEPPER_PHASE_SEQUENCER_MACROS_SVH
`define STEPPER_PHASE_SEQUENCER_MACROS_SVH

// Checked only while out of reset.
`define SPS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define SPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/stpseq_pkg.sv =====
package stpseq_pkg;

    // Command codes
    localparam logic [1:0] CMD_POLL    = 2'd0;
    localparam logic [1:0] CMD_RUN     = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // Step modes
    localparam logic [1:0] MODE_WAVE = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    // Register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_RPM     = 2'd2;

    // Microseconds per minute, numerator of the interval division
    localparam int unsigned IVL_W = 26;
    localparam logic [IVL_W-1:0] US_PER_MIN = 26'd60000000;
    localparam int unsigned DIV_CNT_W = $clog2(IVL_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(IVL_W - 1);

    // Sequence tables (A2=bit0, B1=bit1, A1=bit2, B2=bit3)
    localparam logic [3:0] WAVE_TAB [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] FULL_TAB [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
    localparam logic [3:0] HALF_TAB [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                            4'h4, 4'hC, 4'h8, 4'h9};

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] time_us;
        logic [15:0] step_budget;
    } in_t;

    typedef struct packed {
        logic [3:0] coil_drive;
        logic       stepped;
        logic       running;
        logic [2:0] phase;
    } out_t;

    typedef struct packed {
        logic [1:0]         step_mode;
        logic [15:0]        steps_per_rev;
        logic signed [15:0] speed_rpm;
    } cfg_t;

    typedef struct packed {
        logic             busy;
        logic [IVL_W-1:0] interval;
    } ivl_status_t;

    // Table entry to coil lines A1=bit0, A2=bit1, B1=bit2, B2=bit3
    function automatic logic [3:0] to_lines(input logic [3:0] e);
        return {e[3], e[1], e[0], e[2]};
    endfunction

endpackage

// ===== sv/stpseq_interval.sv =====
// Step interval unit: |rpm| * steps_per_rev, then a restoring divide of
// US_PER_MIN by that product, one quotient bit per cycle.
module stpseq_interval
    import stpseq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  cfg_t        cfg,
    output ivl_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_RUN  = 3'b100
    } ivl_state_t;

    ivl_state_t             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]            prod_reg, prod_next;
    logic [31:0]            rem_reg, rem_next;
    logic [IVL_W-1:0]       quo_reg, quo_next;
    logic [IVL_W-1:0]       ivl_reg, ivl_next;

    logic [16:0] rpm_mag;
    logic [32:0] rem_sh;
    logic        fits;

    assign rpm_mag = cfg.speed_rpm[15] ? (17'd0 - {cfg.speed_rpm[15], cfg.speed_rpm})
                                       : {1'b0, cfg.speed_rpm};
    assign rem_sh  = {rem_reg, quo_reg[IVL_W-1]};
    assign fits    = rem_sh >= {1'b0, prod_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        ivl_next   = ivl_reg;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_LOAD: begin
                // a magnitude of at most 2^15 times 16 bits always fits in 32
                prod_next  = 32'(rpm_mag * cfg.steps_per_rev);
                rem_next   = '0;
                quo_next   = US_PER_MIN;
                cnt_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                rem_next = fits ? 32'(rem_sh - {1'b0, prod_reg}) : rem_sh[31:0];
                quo_next = {quo_reg[IVL_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    ivl_next   = (prod_reg == '0) ? '0 : quo_next;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (start) begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ivl_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ivl_reg   <= ivl_next;
        end
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign status.busy     = start || (state_reg != ST_IDLE);
    assign status.interval = ivl_reg;

endmodule

// ===== sv/stpseq_step.sv =====
// Motor state and result register: one item per enabled cycle.
module stpseq_step
    import stpseq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  in_t              item,
    input  cfg_t             cfg,
    input  logic [IVL_W-1:0] interval,
    output out_t             result
);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [15:0] remain_reg, remain_next;
    logic        run_reg, run_next;
    logic [3:0]  coil_reg, coil_next;
    out_t        out_reg, out_next;

    logic [31:0] elapsed;
    logic        due;
    logic        back;
    logic        stepped;
    logic [1:0]  p4;

    assign elapsed = item.time_us - stamp_reg;
    assign due     = run_reg && (interval != '0) && (elapsed >= {6'd0, interval});
    assign back    = cfg.speed_rpm[15];
    assign p4      = back ? (phase_reg[1:0] - 2'd1) : (phase_reg[1:0] + 2'd1);

    always_comb begin
        phase_next  = phase_reg;
        stamp_next  = stamp_reg;
        remain_next = remain_reg;
        run_next    = run_reg;
        coil_next   = coil_reg;
        stepped     = 1'b0;
        unique case (item.cmd)
            CMD_POLL: begin
                if (due) begin
                    stepped    = 1'b1;
                    stamp_next = item.time_us;
                    unique case (cfg.step_mode)
                        MODE_WAVE: begin
                            phase_next = {1'b0, p4};
                            coil_next  = to_lines(WAVE_TAB[p4]);
                        end
                        MODE_FULL: begin
                            phase_next = {1'b0, p4};
                            coil_next  = to_lines(FULL_TAB[p4]);
                        end
                        MODE_HALF: begin
                            phase_next = back ? (phase_reg - 3'd1) : (phase_reg + 3'd1);
                            coil_next  = to_lines(HALF_TAB[phase_next]);
                        end
                        default: begin
                            coil_next = '0;
                        end
                    endcase
                    if (remain_reg != '0) begin
                        remain_next = remain_reg - 16'd1;
                        // last budgeted step releases the motor
                        if (remain_reg == 16'd1) begin
                            run_next  = 1'b0;
                            coil_next = '0;
                        end
                    end
                end
            end
            CMD_RUN: begin
                run_next    = 1'b1;
                remain_next = item.step_budget;
                stamp_next  = item.time_us;
            end
            CMD_RELEASE: begin
                run_next    = 1'b0;
                remain_next = '0;
                coil_next   = '0;
            end
            default: begin
            end
        endcase
        out_next.coil_drive = coil_next;
        out_next.stepped    = stepped;
        out_next.running    = run_next;
        out_next.phase      = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            stamp_reg  <= '0;
            remain_reg <= '0;
            run_reg    <= 1'b0;
            coil_reg   <= '0;
        end else if (en) begin
            phase_reg  <= phase_next;
            stamp_reg  <= stamp_next;
            remain_reg <= remain_next;
            run_reg    <= run_next;
            coil_reg   <= coil_next;
        end
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

// ===== sv/stepper_phase_sequencer.sv =====
// Four-wire stepper phase sequencer. Each input item (poll, run, release or
// an unused code) yields exactly one result item with the coil lines, a
// stepped flag, the running flag and the phase index after that item. Items
// stream at one per clock while neither the output side nor the interval
// unit stalls; an item is registered in the input register on entry, and its
// result is registered in the result register when the item advances, which
// raises m_valid. A result waiting on m_ready does not stop the next item
// from being taken into the input register. Every configuration write to a
// listed index recomputes the step interval 60000000 / (|speed_rpm| *
// steps_per_rev) in the interval unit: first the product, then a restoring
// divider that yields one quotient bit per cycle, so s_ready is low in the
// cycle of each such write and until the unit is idle again. Configuration
// writes are taken at any time and need the block idle to be meaningful.
module stepper_phase_sequencer
    import stpseq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // item input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    cfg_t        cfg_reg, cfg_next;
    logic        in_valid_reg, in_valid_next;
    in_t         in_reg;
    logic        m_valid_reg, m_valid_next;
    ivl_status_t ivl;
    logic        cfg_hit;
    logic        adv;      // input stage hands its item to the result stage
    logic        take;     // new item accepted

    // Configuration registers; writes to an index past the list do nothing.
    always_comb begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                REG_STEP_MODE: begin
                    cfg_next.step_mode = cfg_wr_data[1:0];
                    cfg_hit            = 1'b1;
                end
                REG_STEPS_PER_REV: begin
                    cfg_next.steps_per_rev = cfg_wr_data;
                    cfg_hit                = 1'b1;
                end
                REG_SPEED_RPM: begin
                    cfg_next.speed_rpm = cfg_wr_data;
                    cfg_hit            = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_mode     <= MODE_FULL;
            cfg_reg.steps_per_rev <= 16'd200;
            cfg_reg.speed_rpm     <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Interval unit; its reset value (zero) matches the reset speed of zero.
    stpseq_interval u_interval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_hit),
        .cfg     (cfg_reg),
        .status  (ivl)
    );

    // Two-stage flow: input register, then result register.
    assign adv     = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !ivl.busy && (!in_valid_reg || adv);
    assign take    = s_valid && s_ready;

    assign in_valid_next = take ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
    assign m_valid_next  = adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        if (take) begin
            in_reg <= s_data;
        end
    end

    stpseq_step u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .item     (in_reg),
        .cfg      (cfg_reg),
        .interval (ivl.interval),
        .result   (m_data)
    );

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/stpseq_checker.sv =====
`include "stepper_phase_sequencer_macros.svh"

module stpseq_checker
    import stpseq_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a stalled result holds
    `SPS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // coils are off whenever the motor is stopped
    `SPS_ASSERT(a_stopped_off, aclk, aresetn, m_valid && !m_data.running |-> m_data.coil_drive == 4'd0, "coils driven while stopped")

    // no step pattern drives all four coils at once
    `SPS_ASSERT(a_step_run, aclk, aresetn, m_valid && m_data.stepped && m_data.running |-> !(m_data.coil_drive == 4'hF), "all four coils driven")

    // no result right after reset
    `SPS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind stepper_phase_sequencer stpseq_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== bench/stepper_phase_sequencer_test.sv =====
module stepper_phase_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stpseq_pkg::*;

    // Codes that the package leaves unnamed but the field widths allow.
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [31:0] US_PER_MINUTE = 32'd60_000_000;
    localparam int LIMIT_CYCLES = 600_000;
    localparam int DRAIN_LIMIT  = 20_000;

    // ------------------------------------------------------------------
    // Clock and block inputs; every input has a known value from time 0.
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    stepper_phase_sequencer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: configuration as last written, motor state.
    // ------------------------------------------------------------------
    logic [1:0]  cfg_mode = MODE_FULL;
    logic [15:0] cfg_rpm  = 16'd0;   // two's complement pattern
    logic [31:0] cur_ivl  = 32'd0;

    logic [2:0]  sh_phase = 3'd0;
    logic [31:0] sh_stamp = 32'd0;
    logic [15:0] sh_left  = 16'd0;
    logic        sh_run   = 1'b0;
    logic [3:0]  sh_coils = 4'd0;

    in_t  cmd_pending_q[$];      // items waiting for the driver
    out_t expected_drive_q[$];   // predicted results, oldest first

    int failures     = 0;
    int results_seen = 0;
    int cycle_cnt    = 0;

    // Pacing controls, per phase.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int tx_gap    = 0;
    int rx_gap    = 0;
    int hold_cnt  = 0;

    // Step interval in us; zero product means no stepping.
    function automatic logic [31:0] step_interval(input logic [15:0] spr,
                                                  input logic [15:0] rpm);
        logic [16:0] mag;
        logic [31:0] prod;
        mag  = rpm[15] ? (17'h10000 - {1'b0, rpm}) : {1'b0, rpm};
        prod = 32'(mag) * 32'(spr);
        return (prod == 32'd0) ? 32'd0 : US_PER_MINUTE / prod;
    endfunction

    // Sequence entry for mode/phase, then remapped onto the coil lines.
    function automatic logic [3:0] coil_pattern(input logic [1:0] mode,
                                                input logic [2:0] ph);
        logic [3:0] e;
        case (mode)
            MODE_WAVE: e = 4'h1 << ph[1:0];
            MODE_FULL: begin
                case (ph[1:0])
                    2'd0: e = 4'h3;
                    2'd1: e = 4'h6;
                    2'd2: e = 4'hC;
                    default: e = 4'h9;
                endcase
            end
            MODE_HALF: begin
                case (ph)
                    3'd0: e = 4'h1;
                    3'd1: e = 4'h3;
                    3'd2: e = 4'h2;
                    3'd3: e = 4'h6;
                    3'd4: e = 4'h4;
                    3'd5: e = 4'hC;
                    3'd6: e = 4'h8;
                    default: e = 4'h9;
                endcase
            end
            default: e = 4'h0;
        endcase
        // entry bit0 -> A2, bit1 -> B1, bit2 -> A1, bit3 -> B2
        return {e[3], e[1], e[0], e[2]};
    endfunction

    // Apply one item to the shadow state and return the result it yields.
    function automatic out_t predict_drive(input in_t it);
        out_t        r;
        logic        st;
        logic [2:0]  nx;
        logic [31:0] elapsed;
        st      = 1'b0;
        elapsed = it.time_us - sh_stamp;   // wraps modulo 2^32
        case (it.cmd)
            CMD_POLL: begin
                if (sh_run && cur_ivl != 32'd0 && elapsed >= cur_ivl) begin
                    // backward steps add size-1, i.e. subtract one
                    case (cfg_mode)
                        MODE_WAVE, MODE_FULL: begin
                            nx       = cfg_rpm[15] ? sh_phase + 3'd3 : sh_phase + 3'd1;
                            sh_phase = {1'b0, nx[1:0]};
                        end
                        MODE_HALF: begin
                            sh_phase = cfg_rpm[15] ? sh_phase + 3'd7 : sh_phase + 3'd1;
                        end
                        default: ;   // unused mode keeps the phase
                    endcase
                    sh_coils = coil_pattern(cfg_mode, sh_phase);
                    sh_stamp = it.time_us;
                    st       = 1'b1;
                    if (sh_left != 16'd0) begin
                        sh_left = sh_left - 16'd1;
                        if (sh_left == 16'd0) begin
                            // budget used up: release on this very step
                            sh_run   = 1'b0;
                            sh_coils = 4'd0;
                        end
                    end
                end
            end
            CMD_RUN: begin
                sh_run   = 1'b1;
                sh_left  = it.step_budget;
                sh_stamp = it.time_us;
            end
            CMD_RELEASE: begin
                sh_run   = 1'b0;
                sh_left  = 16'd0;
                sh_coils = 4'd0;
            end
            default: ;   // ignored command
        endcase
        r.coil_drive = sh_coils;
        r.stepped    = st;
        r.running    = sh_run;
        r.phase      = sh_phase;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents pending items, holds each until accepted.
    // Prediction runs at the edge that accepts the item.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_drive_q.push_back(predict_drive(s_data));
                tx_gap = tx_steady ? 0 : pick_gap();
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (cmd_pending_q.size() != 0) begin
                    s_data  <= cmd_pending_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Compare one result item with the oldest prediction.
    task automatic check_drive(input out_t got);
        out_t exp_r;
        if (expected_drive_q.size() == 0) begin
            $error("result item with no expected item pending: %p", got);
            failures++;
        end else begin
            exp_r = expected_drive_q.pop_front();
            if (got.coil_drive !== exp_r.coil_drive) begin
                $error("coil_drive: expected %0h, actual %0h", exp_r.coil_drive,
                       got.coil_drive);
                failures++;
            end
            if (got.stepped !== exp_r.stepped) begin
                $error("stepped: expected %0b, actual %0b", exp_r.stepped, got.stepped);
                failures++;
            end
            if (got.running !== exp_r.running) begin
                $error("running: expected %0b, actual %0b", exp_r.running, got.running);
                failures++;
            end
            if (got.phase !== exp_r.phase) begin
                $error("phase: expected %0d, actual %0d", exp_r.phase, got.phase);
                failures++;
            end
        end
        results_seen++;
        // long receiver hold-off while the sender keeps offering items
        if (results_seen % 500 == 250)
            hold_cnt = 400;
    endtask

    // ------------------------------------------------------------------
    // Monitor: checks results and paces m_ready.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_drive(m_data);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                rx_gap = (rx_steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
                m_ready <= (rx_gap == 0);
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] cmd, input logic [31:0] t,
                             input logic [15:0] b);
        in_t it;
        it.cmd         = cmd;
        it.time_us     = t;
        it.step_budget = b;
        cmd_pending_q.push_back(it);
    endtask

    // Sender pause: everything offered, accepted and answered.
    // Checked at the falling edge, once the driver's updates have settled.
    task automatic wait_drained();
        while (cmd_pending_q.size() != 0 || s_valid || expected_drive_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= data;
    endtask

    // Only written with the block idle; the shadow follows at once.
    task automatic set_config(input logic [1:0] mode, input logic [15:0] spr,
                              input logic [15:0] rpm);
        wait_drained();
        write_reg(REG_STEP_MODE, {14'd0, mode});
        write_reg(REG_STEPS_PER_REV, spr);
        write_reg(REG_SPEED_RPM, rpm);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_mode = mode;
        cfg_rpm  = rpm;
        cur_ivl  = step_interval(spr, rpm);
    endtask

    // Time advance around the interval: early, exact, late, or a wild jump.
    function automatic logic [31:0] pick_delta(input logic [31:0] ivl);
        int r;
        r = $urandom_range(0, 99);
        if (ivl == 32'd0) return 32'($urandom_range(0, 5000));
        if (r < 40) return ivl + 32'($urandom_range(0, 3));
        if (r < 55) return ivl - 32'd1;
        if (r < 70) return $urandom() % ivl;
        if (r < 85) return ivl;
        return $urandom();
    endfunction

    function automatic logic [15:0] pick_budget();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 16'd0;
        if (r < 80) return 16'($urandom_range(1, 8));
        if (r < 90) return 16'($urandom());
        return 16'hFFFF;
    endfunction

    // Mostly run + polls (+ release) with random content, some noise items.
    task automatic random_phase(input int n_items);
        logic [31:0] t_now;
        logic [1:0]  c;
        int          sent;
        int          pause_at;
        int          polls;
        t_now    = $urandom();
        sent     = 0;
        pause_at = $urandom_range(5, n_items - 5);
        while (sent < n_items) begin
            if (pause_at > 0 && sent >= pause_at) begin
                wait_drained();
                pause_at = 0;
            end
            if ($urandom_range(0, 99) < 80) begin
                push_item(CMD_RUN, t_now, pick_budget());
                sent++;
                polls = $urandom_range(1, 16);
                repeat (polls) begin
                    t_now += pick_delta(cur_ivl);
                    push_item(CMD_POLL, t_now, 16'($urandom()));
                    sent++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    t_now += pick_delta(cur_ivl);
                    push_item(CMD_RELEASE, t_now, 16'($urandom()));
                    sent++;
                end
            end else begin
                c = 2'($urandom_range(0, 3));
                push_item(c, ($urandom_range(0, 1) == 1) ? $urandom() : t_now,
                          16'($urandom()));
                if (c != CMD_UNUSED)
                    sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          drain;
        logic [31:0] t0;
        logic [1:0]  r_mode;
        logic [15:0] r_spr;
        logic [15:0] r_rpm;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset config: full step, 200 steps/rev, 0 rpm -> no stepping.
        push_item(CMD_UNUSED, 32'd0, 16'd0);         // ignored command
        push_item(CMD_POLL, 32'd5, 16'hFFFF);        // poll while stopped
        push_item(CMD_RUN, 32'd100, 16'd0);
        push_item(CMD_POLL, 32'd100000, 16'd0);      // zero interval
        push_item(CMD_RELEASE, 32'd100001, 16'd0);

        // 1000 us interval; budget of two across the timestamp wrap.
        set_config(MODE_FULL, 16'd200, 16'd300);
        t0 = 32'hFFFF_FF00;
        push_item(CMD_RUN, t0, 16'd2);
        push_item(CMD_POLL, t0 + 32'd999, 16'd0);    // one short of due
        push_item(CMD_POLL, t0 + 32'd1000, 16'd0);   // due, wrapped
        push_item(CMD_UNUSED, t0 + 32'd1500, 16'd7); // ignored while running
        push_item(CMD_POLL, t0 + 32'd2000, 16'd0);   // budget end releases
        push_item(CMD_POLL, t0 + 32'd7000, 16'd0);   // stopped again

        // Half step backward.
        set_config(MODE_HALF, 16'd200, -16'sd300);
        push_item(CMD_RUN, 32'd0, 16'd0);
        push_item(CMD_POLL, 32'd1000, 16'd0);
        push_item(CMD_POLL, 32'd2000, 16'd0);
        push_item(CMD_POLL, 32'd3000, 16'd0);

        // Mode change to wave: phase folds modulo 4 on next step.
        set_config(MODE_WAVE, 16'd200, 16'd300);
        push_item(CMD_POLL, 32'd4000, 16'd0);

        // Unused mode: step counts but coils go off, phase kept.
        set_config(MODE_UNUSED, 16'd200, 16'd300);
        push_item(CMD_POLL, 32'd5000, 16'd0);
        push_item(CMD_RELEASE, 32'd5001, 16'd0);

        // Largest magnitude negative speed, single step per rev.
        set_config(MODE_FULL, 16'd1, 16'h8000);
        push_item(CMD_RUN, 32'hFFFF_FFFF, 16'hFFFF);
        push_item(CMD_POLL, 32'd1830, 16'hFFFF);
        push_item(CMD_POLL, 32'hFFFF_FFFF, 16'hFFFF);
        push_item(CMD_RELEASE, 32'hFFFF_FFFF, 16'hFFFF);

        // Random phases; the first few pin the register extremes.
        for (int k = 0; k < 12; k++) begin
            case (k)
                0: begin r_mode = MODE_FULL;   r_spr = 16'd200;   r_rpm = 16'd300;    end
                1: begin r_mode = MODE_WAVE;   r_spr = 16'd1;     r_rpm = 16'd1;      end
                2: begin r_mode = MODE_HALF;   r_spr = 16'hFFFF;  r_rpm = 16'd1;      end
                3: begin r_mode = MODE_UNUSED; r_spr = 16'd48;    r_rpm = 16'd250;    end
                4: begin r_mode = MODE_HALF;   r_spr = 16'd200;   r_rpm = 16'h8000;   end
                5: begin r_mode = MODE_WAVE;   r_spr = 16'hFFFF;  r_rpm = 16'h7FFF;   end
                6: begin r_mode = MODE_FULL;   r_spr = 16'd0;     r_rpm = 16'hFFFF;   end
                default: begin
                    r_mode = 2'($urandom_range(0, 3));
                    r_spr  = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(1, 400))
                                                           : 16'($urandom());
                    r_rpm  = ($urandom_range(0, 99) < 85)
                           ? 16'($urandom_range(0, 1200)) - 16'd600
                           : 16'($urandom());
                end
            endcase
            set_config(r_mode, r_spr, r_rpm);
            tx_steady = (k % 4 == 1);
            rx_steady = (k % 4 == 2);
            random_phase(100);
        end

        // All offered, then drain what is still in flight.
        while (cmd_pending_q.size() != 0 || s_valid)
            @(negedge aclk);
        drain = 0;
        while (expected_drive_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        if (expected_drive_q.size() != 0) begin
            $error("%0d expected result items never arrived", expected_drive_q.size());
            failures++;
        end
        repeat (8) @(posedge aclk);

        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/stpseq_pkg.sv
sv/stpseq_interval.sv
sv/stpseq_step.sv
sv/stepper_phase_sequencer.sv
sv/stpseq_checker.sv
bench/stepper_phase_sequencer_test.sv
